[hw/rtl/searchable_lifo_stack_defines.svh]
// ---------------------------------------------------------------------------
// searchable_lifo_stack_defines.svh
// Assertion macros shared by the stack's checker files.
// ---------------------------------------------------------------------------
`ifndef SEARCHABLE_LIFO_STACK_DEFINES_SVH
`define SEARCHABLE_LIFO_STACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sls_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sls_pkg
// Shared sizes, codes and the per-cell command for the searchable stack.
// ---------------------------------------------------------------------------
package sls_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // Action codes carried by an item
  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_FIND    = 3'd3,
    ACT_REVERSE = 3'd4,
    ACT_CLEAR   = 3'd5
  } act_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  // What every cell does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_REMOVE,
    CELL_REV_SHIFT,
    CELL_REV_COPY
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [VALUE_WIDTH-1:0]   value;
  } cell_cmd_t;

endpackage

[hw/rtl/sls_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sls_cell
// One stack position: a main entry register, an auxiliary register used
// while reversing, and a compare against the broadcast search value.
// ---------------------------------------------------------------------------
module sls_cell (
  input  logic                               clk_i,
  input  sls_pkg::cell_cmd_t                 cmd_i,
  input  logic                               valid_i,  // position is held
  input  logic [sls_pkg::VALUE_WIDTH-1:0]    a_up_i,   // main entry nearer the top
  input  logic [sls_pkg::VALUE_WIDTH-1:0]    a_dn_i,   // main entry nearer the bottom
  input  logic [sls_pkg::VALUE_WIDTH-1:0]    b_up_i,   // auxiliary entry nearer the top
  input  logic                               match_i,  // a match sits above this cell
  output logic                               match_o,
  output logic [sls_pkg::VALUE_WIDTH-1:0]    a_o,
  output logic [sls_pkg::VALUE_WIDTH-1:0]    b_o
);

  logic [sls_pkg::VALUE_WIDTH-1:0] a_q, a_d;
  logic [sls_pkg::VALUE_WIDTH-1:0] b_q, b_d;

  // Match chain: set from the topmost held match downwards
  assign match_o = match_i | (valid_i & (a_q == cmd_i.value));

  // Next entry values
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    unique case (cmd_i.op)
      sls_pkg::CELL_PUSH:      a_d = a_up_i;
      sls_pkg::CELL_POP:       a_d = a_dn_i;
      sls_pkg::CELL_REMOVE: begin
        if (match_o) begin
          a_d = a_dn_i;
        end
      end
      sls_pkg::CELL_REV_SHIFT: begin
        a_d = a_dn_i;
        b_d = b_up_i;
      end
      sls_pkg::CELL_REV_COPY:  a_d = b_q;
      default:                 ;
    endcase
  end

  // Entry storage, no reset: only held positions are ever read
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

[hw/rtl/searchable_lifo_stack.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// searchable_lifo_stack
// Bounded LIFO stack with push, pop, remove-by-value, find, reverse and
// clear, built as a row of cells with the top of stack in cell 0.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------
//  command  | start / busy         | action_i, value_i
//  result   | valid_o (one cycle)  | status_o, out_value_o, entry_count_o
//
//  Push, pop, remove, find, clear and unused codes are answered from the
//  result registers: the result is on the ports the cycle after the item is
//  taken, and a new item may be taken in that same cycle.
//  Reverse of n >= 2 entries holds busy high for n shifts
//  through the auxiliary cell chain, then one parallel copy back.
//  Reset clears the entry count and the control state; cell contents are
//  left as they are. Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module searchable_lifo_stack (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          action_i,
  input  logic [sls_pkg::VALUE_WIDTH-1:0]     value_i,
  output logic                                valid_o,
  output logic [1:0]                          status_o,
  output logic [sls_pkg::VALUE_WIDTH-1:0]     out_value_o,
  output logic [sls_pkg::CNT_W-1:0]           entry_count_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REV_SHIFT,
    ST_REV_COPY
  } state_e;

  state_e                          state_q, state_d;
  logic [sls_pkg::CNT_W-1:0]       held_q, held_d;
  logic [sls_pkg::CNT_W-1:0]       rev_cnt_q, rev_cnt_d;
  logic                            valid_q, valid_d;
  sls_pkg::status_e                status_q, status_d;
  logic [sls_pkg::VALUE_WIDTH-1:0] out_value_q, out_value_d;

  sls_pkg::cell_cmd_t              cmd;
  logic [sls_pkg::VALUE_WIDTH-1:0] a_w [sls_pkg::DEPTH];
  logic [sls_pkg::VALUE_WIDTH-1:0] b_w [sls_pkg::DEPTH];
  logic [sls_pkg::DEPTH:0]         match_w;
  logic                            match_any;

  assign match_w[0] = 1'b0;
  assign match_any  = match_w[sls_pkg::DEPTH];

  // Row of cells, cell 0 is the top of stack
  for (genvar i = 0; i < sls_pkg::DEPTH; i++) begin : g_cell
    logic [sls_pkg::VALUE_WIDTH-1:0] a_up, a_dn, b_up;
    logic                            cell_valid;

    assign cell_valid = (held_q > sls_pkg::CNT_W'(i));

    if (i == 0) begin : g_top
      assign a_up = cmd.value;
      assign b_up = a_w[0];
    end else begin : g_mid
      assign a_up = a_w[i-1];
      assign b_up = b_w[i-1];
    end

    if (i == sls_pkg::DEPTH - 1) begin : g_bottom
      assign a_dn = '0;
    end else begin : g_upper
      assign a_dn = a_w[i+1];
    end

    sls_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .valid_i (cell_valid),
      .a_up_i  (a_up),
      .a_dn_i  (a_dn),
      .b_up_i  (b_up),
      .match_i (match_w[i]),
      .match_o (match_w[i+1]),
      .a_o     (a_w[i]),
      .b_o     (b_w[i])
    );
  end

  // Control: decode an item, sequence a reverse
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    rev_cnt_d   = rev_cnt_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    out_value_d = out_value_q;
    cmd.op      = sls_pkg::CELL_HOLD;
    cmd.value   = value_i;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          valid_d     = 1'b1;
          status_d    = sls_pkg::STS_OK;
          out_value_d = '0;
          case (sls_pkg::act_e'(action_i))
            sls_pkg::ACT_PUSH: begin
              if (held_q == sls_pkg::CNT_W'(sls_pkg::DEPTH)) begin
                status_d = sls_pkg::STS_FULL;
              end else begin
                cmd.op = sls_pkg::CELL_PUSH;
                held_d = held_q + 1'b1;
              end
            end
            sls_pkg::ACT_POP: begin
              if (held_q == '0) begin
                status_d = sls_pkg::STS_MISS;
              end else begin
                cmd.op      = sls_pkg::CELL_POP;
                out_value_d = a_w[0];
                held_d      = held_q - 1'b1;
              end
            end
            sls_pkg::ACT_REMOVE: begin
              if (match_any) begin
                cmd.op      = sls_pkg::CELL_REMOVE;
                out_value_d = value_i;
                held_d      = held_q - 1'b1;
              end else begin
                status_d = sls_pkg::STS_MISS;
              end
            end
            sls_pkg::ACT_FIND: begin
              if (!match_any) begin
                status_d = sls_pkg::STS_MISS;
              end
            end
            sls_pkg::ACT_REVERSE: begin
              // short stacks are already their own reverse
              if (held_q > sls_pkg::CNT_W'(1)) begin
                valid_d   = 1'b0;
                rev_cnt_d = held_q;
                state_d   = ST_REV_SHIFT;
              end
            end
            sls_pkg::ACT_CLEAR: held_d = '0;
            default:            ;
          endcase
        end
      end
      ST_REV_SHIFT: begin
        cmd.op    = sls_pkg::CELL_REV_SHIFT;
        rev_cnt_d = rev_cnt_q - 1'b1;
        if (rev_cnt_q == sls_pkg::CNT_W'(1)) begin
          state_d = ST_REV_COPY;
        end
      end
      ST_REV_COPY: begin
        cmd.op      = sls_pkg::CELL_REV_COPY;
        valid_d     = 1'b1;
        status_d    = sls_pkg::STS_OK;
        out_value_d = '0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      rev_cnt_q   <= '0;
      valid_q     <= 1'b0;
      status_q    <= sls_pkg::STS_OK;
      out_value_q <= '0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      rev_cnt_q   <= rev_cnt_d;
      valid_q     <= valid_d;
      status_q    <= status_d;
      out_value_q <= out_value_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign out_value_o   = out_value_q;
  assign entry_count_o = held_q;

endmodule

[hw/rtl/sls_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sls_checker
// Port-level checks on the searchable stack, bound to the top level.
// ---------------------------------------------------------------------------
`include "searchable_lifo_stack_defines.svh"

module sls_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic [2:0]                          action_i,
  input  logic                                valid_o,
  input  logic [1:0]                          status_o,
  input  logic [sls_pkg::VALUE_WIDTH-1:0]     out_value_o,
  input  logic [sls_pkg::CNT_W-1:0]           entry_count_o
);

  logic take_short;

  // every item except a reverse answers in the next cycle
  assign take_short = start && !busy && (action_i != sls_pkg::ACT_REVERSE);

  `SLS_ASSERT_NXT(a_short_answers, clk_i, rst_ni, take_short, valid_o, "item gave no result")
  `SLS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, valid_o,
                  entry_count_o <= sls_pkg::CNT_W'(sls_pkg::DEPTH), "entry count past depth")
  `SLS_ASSERT_IMP(a_full_count, clk_i, rst_ni, valid_o && (status_o == sls_pkg::STS_FULL),
                  entry_count_o == sls_pkg::CNT_W'(sls_pkg::DEPTH), "full status below depth")
  `SLS_ASSERT_IMP(a_refused_zero, clk_i, rst_ni, valid_o && (status_o != sls_pkg::STS_OK),
                  out_value_o == '0, "refused item returned a value")

endmodule

bind searchable_lifo_stack sls_checker u_sls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .action_i      (action_i),
  .valid_o       (valid_o),
  .status_o      (status_o),
  .out_value_o   (out_value_o),
  .entry_count_o (entry_count_o)
);

[bench/tb_searchable_lifo_stack.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_searchable_lifo_stack
// Self-checking bench for the searchable stack. A queue of stack actions is
// built up front, a short directed list and then random phases that favour
// filling, draining or a mix. The driver presents one item at a time with
// random idle gaps. The monitor predicts every accepted item against a
// bottom-up copy of the stack and compares each result strobe in order.
// ---------------------------------------------------------------------------
module tb_searchable_lifo_stack;
  import sls_pkg::*;

  // Codes six and seven are not decoded by the block
  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [2:0]             action;
    logic [VALUE_WIDTH-1:0] value;
    int unsigned            gap;
  } stack_cmd_t;

  typedef struct {
    status_e                status;
    logic [VALUE_WIDTH-1:0] value;
    logic [CNT_W-1:0]       count;
  } stack_res_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [2:0]             action_i;
  logic [VALUE_WIDTH-1:0] value_i;
  logic                   valid_o;
  logic [1:0]             status_o;
  logic [VALUE_WIDTH-1:0] out_value_o;
  logic [CNT_W-1:0]       entry_count_o;

  searchable_lifo_stack dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .value_i       (value_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .entry_count_o (entry_count_o)
  );

  // Clock: 8 ns period
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  stack_cmd_t             pending_q[$];
  stack_res_t             result_q[$];

  // Predicted stack contents, cell 0 at the bottom
  logic [VALUE_WIDTH-1:0] model_cells [DEPTH];
  int unsigned            model_fill;

  stack_cmd_t             cur_cmd;
  bit                     have_cmd;
  int unsigned            idle_left;
  bit                     item_taken;
  bit                     no_idle;

  int unsigned            errors;
  int unsigned            n_accepted;
  int unsigned            n_checked;
  int unsigned            n_full;
  int unsigned            n_miss;
  int unsigned            n_reverse;

  // Index of the topmost held entry equal to val, or -1
  function automatic int topmost_index(logic [VALUE_WIDTH-1:0] val);
    for (int i = int'(model_fill) - 1; i >= 0; i--) begin
      if (model_cells[i] == val) return i;
    end
    return -1;
  endfunction

  // Apply one action to the predicted stack and return its result
  function automatic stack_res_t apply_stack_action(logic [2:0] act,
                                                    logic [VALUE_WIDTH-1:0] val);
    stack_res_t             res;
    int                     pos;
    logic [VALUE_WIDTH-1:0] tmp;
    res.status = STS_OK;
    res.value  = '0;
    case (act)
      ACT_PUSH: begin
        if (model_fill >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          model_cells[model_fill] = val;
          model_fill++;
        end
      end
      ACT_POP: begin
        if (model_fill == 0) begin
          res.status = STS_MISS;
        end else begin
          model_fill--;
          res.value = model_cells[model_fill];
        end
      end
      ACT_REMOVE: begin
        pos = topmost_index(val);
        if (pos < 0) begin
          res.status = STS_MISS;
        end else begin
          res.value = model_cells[pos];
          // entries above the match close the gap, order kept
          for (int i = pos; i + 1 < int'(model_fill); i++)
            model_cells[i] = model_cells[i + 1];
          model_fill--;
        end
      end
      ACT_FIND: begin
        if (topmost_index(val) < 0) res.status = STS_MISS;
      end
      ACT_REVERSE: begin
        for (int i = 0; i < int'(model_fill / 2); i++) begin
          tmp                             = model_cells[i];
          model_cells[i]                  = model_cells[model_fill - 1 - i];
          model_cells[model_fill - 1 - i] = tmp;
        end
      end
      ACT_CLEAR: model_fill = 0;
      default: ;
    endcase
    res.count = CNT_W'(model_fill);
    return res;
  endfunction

  task automatic queue_item(logic [2:0] act, logic [VALUE_WIDTH-1:0] val);
    stack_cmd_t cmd;
    cmd.action = act;
    cmd.value  = val;
    cmd.gap    = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    pending_q.push_back(cmd);
  endtask

  // Driver: inputs move on the falling edge only
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(start && !item_taken)) begin
        if (!have_cmd && pending_q.size() > 0) begin
          cur_cmd   = pending_q.pop_front();
          have_cmd  = 1'b1;
          idle_left = cur_cmd.gap;
        end
        if (have_cmd && idle_left == 0) begin
          start    <= 1'b1;
          action_i <= cur_cmd.action;
          value_i  <= cur_cmd.value;
          have_cmd  = 1'b0;
        end else begin
          if (have_cmd) idle_left--;
          // junk on the payload while idle
          start    <= 1'b0;
          action_i <= 3'($urandom);
          value_i  <= VALUE_WIDTH'($urandom);
        end
      end
    end
  end

  // Monitor: check result strobes, predict accepted items
  always @(posedge clk_i) begin
    stack_res_t exp_res;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (valid_o) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d value %h count %0d",
                   $time, status_o, out_value_o, entry_count_o);
        end else begin
          exp_res = result_q.pop_front();
          n_checked++;
          if (status_o !== exp_res.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d",
                     $time, exp_res.status, status_o);
          end
          if (out_value_o !== exp_res.value) begin
            errors++;
            $display("%0t: out_value expected %h, got %h",
                     $time, exp_res.value, out_value_o);
          end
          if (entry_count_o !== exp_res.count) begin
            errors++;
            $display("%0t: entry_count expected %0d, got %0d",
                     $time, exp_res.count, entry_count_o);
          end
        end
      end
      if (start && !busy) begin
        exp_res = apply_stack_action(action_i, value_i);
        result_q.push_back(exp_res);
        item_taken = 1'b1;
        n_accepted++;
        if (exp_res.status == STS_FULL) n_full++;
        if (exp_res.status == STS_MISS) n_miss++;
        if (action_i == ACT_REVERSE && exp_res.count > 1) n_reverse++;
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb_searchable_lifo_stack: done, errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [VALUE_WIDTH-1:0] pool [8];
    int unsigned            phase;
    int unsigned            roll;
    int unsigned            w_push, w_pop, w_rem, w_find, w_rev, w_clr;
    logic [2:0]             act;
    logic [VALUE_WIDTH-1:0] val;

    rst_ni     = 1'b0;
    start      = 1'b0;
    action_i   = '0;
    value_i    = '0;
    have_cmd   = 1'b0;
    idle_left  = 0;
    item_taken = 1'b0;
    model_fill = 0;
    errors     = 0;
    n_accepted = 0;
    n_checked  = 0;
    n_full     = 0;
    n_miss     = 0;
    n_reverse  = 0;
    no_idle    = 1'b0;

    // Directed: empty-stack cases, one-entry reverse, unused code
    queue_item(ACT_POP, '0);
    queue_item(ACT_REMOVE, '1);
    queue_item(ACT_FIND, '0);
    queue_item(ACT_REVERSE, '0);
    queue_item(ACT_PUSH, '1);
    queue_item(ACT_REVERSE, '0);
    queue_item(ACT_UNUSED6, '1);
    // fill to the brim with repeats of a marker value
    for (int i = 1; i < DEPTH; i++)
      queue_item(ACT_PUSH, (i % 4 == 1) ? 32'hA5A5_A5A5 : VALUE_WIDTH'(i));
    queue_item(ACT_PUSH, 32'h1234_5678);
    queue_item(ACT_REMOVE, 32'hA5A5_A5A5);
    queue_item(ACT_REVERSE, '0);
    queue_item(ACT_REMOVE, 32'hDEAD_BEEF);
    queue_item(ACT_CLEAR, '0);

    // Random phases: fill-heavy, drain-heavy or balanced
    pool[0] = '0;
    pool[1] = '1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        phase   = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int k = 2; k < 8; k++) pool[k] = $urandom;
        case (phase)
          0:       begin w_push = 55; w_pop = 10; w_rem = 12; w_find = 12; end
          1:       begin w_push = 20; w_pop = 35; w_rem = 25; w_find = 10; end
          default: begin w_push = 35; w_pop = 20; w_rem = 18; w_find = 15; end
        endcase
        w_rev = 5;
        w_clr = 2;
      end
      roll = $urandom_range(0, 99);
      if (roll < w_push) act = ACT_PUSH;
      else if (roll < w_push + w_pop) act = ACT_POP;
      else if (roll < w_push + w_pop + w_rem) act = ACT_REMOVE;
      else if (roll < w_push + w_pop + w_rem + w_find) act = ACT_FIND;
      else if (roll < w_push + w_pop + w_rem + w_find + w_rev) act = ACT_REVERSE;
      else if (roll < w_push + w_pop + w_rem + w_find + w_rev + w_clr) act = ACT_CLEAR;
      else act = $urandom_range(0, 1) ? ACT_UNUSED6 : ACT_UNUSED7;
      // mostly pool values so that finds and removes hit
      if ($urandom_range(0, 9) < ((act == ACT_PUSH) ? 6 : 8))
        val = pool[$urandom_range(0, 7)];
      else
        val = $urandom;
      queue_item(act, val);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || have_cmd || start || result_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d items, %0d results checked.", n_accepted, n_checked);
    $display("Full refusals %0d, empty or missed %0d, multi-entry reverses %0d.",
             n_full, n_miss, n_reverse);
    if (errors == 0) begin
      $display("tb_searchable_lifo_stack: done, clean");
    end else begin
      $display("tb_searchable_lifo_stack: done, errors");
    end
    $finish;
  end

endmodule
